[hw/rtl/assert_macros.svh]
// Assertion helpers used by the checker file d2q_bgk_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while rst_sig is high.
`define CHK_IMPLY(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, ignored while rst_sig is high.
`define CHK_NEXT(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[hw/rtl/d2q_pkg.sv]
`default_nettype none
package d2q_pkg;

  localparam int NDIR = 9;

  // lattice velocity components per direction
  localparam int EX [NDIR] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
  localparam int EY [NDIR] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};

  // equilibrium weight numerators 16, 4, 1 as shift amounts (over 72)
  localparam int WK_SHIFT [NDIR] = '{4, 2, 2, 2, 2, 0, 0, 0, 0};

  localparam int EQ_DIV  = 72;
  localparam int EQ_HALF = 36;
  localparam int EQ_W    = 64;  // dividend bits for the divide by 72
  localparam int EQ_PRE  = 3;   // 72 = 8 * 9: shift out the 8 first
  localparam int EQ_NINE = 9;
  localparam int EQ_RW   = 7;   // remainder bits after the estimate, holds 0..127
  localparam int EQ_STG  = 3;   // prescale, reciprocal estimate, correction

  // wide products clamp at +-2^56
  localparam int WIDE_LOG = 56;
  localparam int LIM_W    = WIDE_LOG + 1;

endpackage
`default_nettype wire

[hw/rtl/d2q_pipe_ctl.sv]
`default_nettype none
module d2q_pipe_ctl #(
  parameter int STAGES = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [STAGES-1:0] en
);

  logic [STAGES-1:0] vld;

  // a stage loads when it is empty or its content moves on
  always_comb begin
    en[STAGES-1] = !vld[STAGES-1] || out_ready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < STAGES; k++) begin
        if (en[k]) begin
          vld[k] <= (k == 0) ? in_valid : vld[(k == 0) ? 0 : k-1];
        end
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[STAGES-1];

endmodule
`default_nettype wire

[hw/rtl/d2q9_bgk_collision.sv]
// D2Q9 BGK collision, one cell per beat.
// Pipeline: most of its stages are the bit-per-stage velocity divider.
// Throughput: one beat per cycle while the output is not stalled; output stalls back up only into occupied stages.
// Reset: rst (synchronous, active high) empties the pipeline and sets relax_rate to 1.0.
`default_nettype none
module d2q9_bgk_collision #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [FRAC_BITS:0]           cfg_wdata,
  input  logic                         dist_valid,
  output logic                         dist_ready,
  input  logic signed [DATA_WIDTH-1:0] dist_0,
  input  logic signed [DATA_WIDTH-1:0] dist_1,
  input  logic signed [DATA_WIDTH-1:0] dist_2,
  input  logic signed [DATA_WIDTH-1:0] dist_3,
  input  logic signed [DATA_WIDTH-1:0] dist_4,
  input  logic signed [DATA_WIDTH-1:0] dist_5,
  input  logic signed [DATA_WIDTH-1:0] dist_6,
  input  logic signed [DATA_WIDTH-1:0] dist_7,
  input  logic signed [DATA_WIDTH-1:0] dist_8,
  output logic                         result_valid,
  input  logic                         result_ready,
  output logic signed [DATA_WIDTH-1:0] out_0,
  output logic signed [DATA_WIDTH-1:0] out_1,
  output logic signed [DATA_WIDTH-1:0] out_2,
  output logic signed [DATA_WIDTH-1:0] out_3,
  output logic signed [DATA_WIDTH-1:0] out_4,
  output logic signed [DATA_WIDTH-1:0] out_5,
  output logic signed [DATA_WIDTH-1:0] out_6,
  output logic signed [DATA_WIDTH-1:0] out_7,
  output logic signed [DATA_WIDTH-1:0] out_8,
  output logic signed [DATA_WIDTH-1:0] density,
  output logic signed [DATA_WIDTH-1:0] velocity_x,
  output logic signed [DATA_WIDTH-1:0] velocity_y
);
  import d2q_pkg::*;

  localparam int W   = DATA_WIDTH;
  localparam int F   = FRAC_BITS;
  // divider remainder: holds |m| << F and rho << (W-1)
  localparam int DW  = (W + F > 2 * W - 1) ? W + F : 2 * W - 1;
  // 2 + 6eu + 9eu2 - 3usq, kept exact
  localparam int P2W = ((W > F + 2) ? W : F + 2) + 6;
  // product width, wide enough for every multiply in the datapath
  localparam int PX  = (2 * W + F + 8 > 64) ? 2 * W + F + 8 : 64;
  // signed headroom for sums before saturation
  localparam int SW  = (2 * W + F + 16 > 80) ? 2 * W + F + 16 : 80;
  localparam int LW  = LIM_W;
  localparam int RW  = LIM_W + 1;
  // series terms for x/9 = 7x * (1/64 + 1/64^2 + ...), tail below one
  localparam int EQ_K = (W + 4) / 6;

  // stage map
  localparam int S_SUM  = 0;
  localparam int S_SET  = 1;
  localparam int S_DIV0 = 2;
  localparam int S_VEL  = S_DIV0 + W - 1;
  localparam int S_EU   = S_VEL + 1;
  localparam int S_SQ   = S_VEL + 2;
  localparam int S_EU2  = S_VEL + 3;
  localparam int S_P2   = S_VEL + 4;
  localparam int S_PM   = S_VEL + 5;
  localparam int S_T    = S_VEL + 6;
  localparam int S_Q0   = S_VEL + 7;
  localparam int S_DIFF = S_Q0 + EQ_STG;
  localparam int S_RP   = S_DIFF + 1;
  localparam int S_REL  = S_DIFF + 2;
  localparam int S_OUT  = S_DIFF + 3;
  localparam int NS     = S_OUT + 1;

  localparam logic signed [SW-1:0] SMAX_S = SW'((SW'(1) << (W - 1)) - SW'(1));
  localparam logic signed [SW-1:0] SMIN_S = ~SMAX_S;
  localparam logic [W-1:0]         SMAX_W = SMAX_S[W-1:0];
  localparam logic [W-1:0]         SMIN_W = SMIN_S[W-1:0];
  localparam logic signed [SW-1:0] ONE2_S = SW'(SW'(2) << F);

  typedef struct packed {
    logic [NDIR-1:0][W-1:0]      f;
    logic [W-1:0]                rho;
    logic                        pos;
    logic [W-1:0]                mx;
    logic [W-1:0]                my;
    logic                        nx;
    logic                        ny;
    logic                        ox;
    logic                        oy;
    logic [DW-1:0]               rx;
    logic [DW-1:0]               ry;
    logic [W-2:0]                qx;
    logic [W-2:0]                qy;
    logic [W-1:0]                ux;
    logic [W-1:0]                uy;
    logic [NDIR-1:0][W-1:0]      eu;
    logic [PX-1:0]               pxx;
    logic [PX-1:0]               pyy;
    logic [NDIR-1:0][PX-1:0]     prod;
    logic [NDIR-1:0]             sg;
    logic [W-1:0]                usq;
    logic [NDIR-1:0][W-1:0]      eu2;
    logic [NDIR-1:0][P2W-1:0]    p2;
    logic [NDIR-1:0][EQ_W-1:0]   dn;
    logic [NDIR-1:0][EQ_W-1:0]   dq;
    logic [NDIR-1:0]             big;
    logic [NDIR-1:0][W:0]        diff;
    logic [NDIR-1:0][RW-1:0]     rel;
    logic [NDIR-1:0][W-1:0]      o;
  } cell_t;

  function automatic logic signed [SW-1:0] sx(input logic [W-1:0] v);
    return SW'($signed(v));
  endfunction

  function automatic logic [W-1:0] sat(input logic signed [SW-1:0] v);
    if (v > SMAX_S) begin
      return SMAX_W;
    end else if (v < SMIN_S) begin
      return SMIN_W;
    end
    return v[W-1:0];
  endfunction

  function automatic logic [W-1:0] absw(input logic [W-1:0] v);
    return v[W-1] ? (~v + W'(1)) : v;
  endfunction

  // round half away on a magnitude, drop F fraction bits, clamp at 2^56
  function automatic logic [LW-1:0] rq(input logic [PX-1:0] p);
    logic [PX:0] s;
    s = ({1'b0, p} + ((PX+1)'(1) << (F - 1))) >> F;
    if (s > ((PX+1)'(1) << WIDE_LOG)) begin
      return LW'(1) << WIDE_LOG;
    end
    return s[LW-1:0];
  endfunction

  logic [NS-1:0]          en;
  logic [F:0]             relax_rate;
  logic [NDIR-1:0][W-1:0] din;
  cell_t                  st  [NS];
  cell_t                  nxt [NS];

  // 1/tau; the user must write it only while the pipeline is idle, the block does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      relax_rate <= {1'b1, {F{1'b0}}};
    end else if (cfg_we) begin
      relax_rate <= cfg_wdata;
    end
  end

  assign din[0] = dist_0;
  assign din[1] = dist_1;
  assign din[2] = dist_2;
  assign din[3] = dist_3;
  assign din[4] = dist_4;
  assign din[5] = dist_5;
  assign din[6] = dist_6;
  assign din[7] = dist_7;
  assign din[8] = dist_8;

  d2q_pipe_ctl #(
    .STAGES(NS)
  ) u_ctl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (dist_valid),
    .in_ready (dist_ready),
    .out_valid(result_valid),
    .out_ready(result_ready),
    .en       (en)
  );

  for (genvar k = 0; k < NS; k++) begin : g_stage
    if (k == S_SUM) begin : g_sum
      // density and momentum, saturated
      always_comb begin
        logic signed [SW-1:0] sum;
        logic signed [SW-1:0] mxs;
        logic signed [SW-1:0] mys;
        nxt[k] = '0;
        sum = '0;
        for (int q = 0; q < NDIR; q++) begin
          sum = sum + sx(din[q]);
        end
        mxs = sx(din[1]) - sx(din[3]) + sx(din[5]) - sx(din[6]) - sx(din[7]) + sx(din[8]);
        mys = sx(din[2]) - sx(din[4]) + sx(din[5]) + sx(din[6]) - sx(din[7]) - sx(din[8]);
        nxt[k].f   = din;
        nxt[k].rho = sat(sum);
        nxt[k].pos = (sum > 0);
        nxt[k].mx  = sat(mxs);
        nxt[k].my  = sat(mys);
      end
    end else if (k == S_SET) begin : g_set
      // magnitudes and quotient overflow check against rho << (W-1)
      always_comb begin
        logic [W-1:0] ax;
        logic [W-1:0] ay;
        nxt[k] = st[k-1];
        ax = absw(st[k-1].mx);
        ay = absw(st[k-1].my);
        nxt[k].nx = st[k-1].mx[W-1];
        nxt[k].ny = st[k-1].my[W-1];
        nxt[k].rx = DW'(ax) << F;
        nxt[k].ry = DW'(ay) << F;
        nxt[k].ox = (DW'(ax) << F) >= (DW'(st[k-1].rho) << (W - 1));
        nxt[k].oy = (DW'(ay) << F) >= (DW'(st[k-1].rho) << (W - 1));
        nxt[k].qx = '0;
        nxt[k].qy = '0;
      end
    end else if (k < S_VEL) begin : g_div
      localparam int B = W - 2 - (k - S_DIV0);
      // restoring step: one quotient bit per stage, both lanes
      always_comb begin
        logic [DW-1:0] dsh;
        nxt[k] = st[k-1];
        dsh = DW'(st[k-1].rho) << B;
        if (st[k-1].rx >= dsh) begin
          nxt[k].rx    = st[k-1].rx - dsh;
          nxt[k].qx[B] = 1'b1;
        end
        if (st[k-1].ry >= dsh) begin
          nxt[k].ry    = st[k-1].ry - dsh;
          nxt[k].qy[B] = 1'b1;
        end
      end
    end else if (k == S_VEL) begin : g_vel
      // apply sign, saturate, zero the velocity when density is not positive
      always_comb begin
        logic [W-1:0] qex;
        logic [W-1:0] qey;
        nxt[k] = st[k-1];
        qex = {1'b0, st[k-1].qx};
        qey = {1'b0, st[k-1].qy};
        if (!st[k-1].pos) begin
          nxt[k].ux = '0;
          nxt[k].uy = '0;
        end else begin
          if (st[k-1].ox) begin
            nxt[k].ux = st[k-1].nx ? SMIN_W : SMAX_W;
          end else begin
            nxt[k].ux = st[k-1].nx ? (~qex + W'(1)) : qex;
          end
          if (st[k-1].oy) begin
            nxt[k].uy = st[k-1].ny ? SMIN_W : SMAX_W;
          end else begin
            nxt[k].uy = st[k-1].ny ? (~qey + W'(1)) : qey;
          end
        end
      end
    end else if (k == S_EU) begin : g_eu
      always_comb begin
        logic signed [SW-1:0] tx;
        logic signed [SW-1:0] ty;
        logic [W-1:0]         ax;
        logic [W-1:0]         ay;
        logic [2*W-1:0]       mxx;
        logic [2*W-1:0]       myy;
        nxt[k] = st[k-1];
        for (int q = 0; q < NDIR; q++) begin
          tx = '0;
          ty = '0;
          if (EX[q] > 0) begin
            tx = sx(st[k-1].ux);
          end else if (EX[q] < 0) begin
            tx = -sx(st[k-1].ux);
          end
          if (EY[q] > 0) begin
            ty = sx(st[k-1].uy);
          end else if (EY[q] < 0) begin
            ty = -sx(st[k-1].uy);
          end
          nxt[k].eu[q] = sat(tx + ty);
        end
        ax = absw(st[k-1].ux);
        ay = absw(st[k-1].uy);
        mxx = ax * ax;
        myy = ay * ay;
        nxt[k].pxx = PX'(mxx);
        nxt[k].pyy = PX'(myy);
      end
    end else if (k == S_SQ) begin : g_sq
      always_comb begin
        logic [W-1:0]   a;
        logic [2*W-1:0] m;
        nxt[k] = st[k-1];
        for (int q = 0; q < NDIR; q++) begin
          a = absw(st[k-1].eu[q]);
          m = a * a;
          nxt[k].prod[q] = PX'(m);
        end
        nxt[k].usq = sat(SW'(rq(st[k-1].pxx)) + SW'(rq(st[k-1].pyy)));
      end
    end else if (k == S_EU2) begin : g_eu2
      always_comb begin
        nxt[k] = st[k-1];
        for (int q = 0; q < NDIR; q++) begin
          nxt[k].eu2[q] = sat(SW'(rq(st[k-1].prod[q])));
        end
      end
    end else if (k == S_P2) begin : g_p2
      // twice the equilibrium polynomial
      always_comb begin
        logic signed [SW-1:0] e;
        logic signed [SW-1:0] e2;
        logic signed [SW-1:0] u;
        logic signed [SW-1:0] v;
        nxt[k] = st[k-1];
        u = sx(st[k-1].usq);
        for (int q = 0; q < NDIR; q++) begin
          e  = sx(st[k-1].eu[q]);
          e2 = sx(st[k-1].eu2[q]);
          v  = ONE2_S + (e <<< 2) + (e <<< 1) + (e2 <<< 3) + e2 - (u <<< 1) - u;
          nxt[k].p2[q] = v[P2W-1:0];
        end
      end
    end else if (k == S_PM) begin : g_pm
      always_comb begin
        logic [W-1:0]       a;
        logic [P2W-1:0]     b;
        logic [W+P2W-1:0]   m;
        nxt[k] = st[k-1];
        a = absw(st[k-1].rho);
        for (int q = 0; q < NDIR; q++) begin
          b = st[k-1].p2[q][P2W-1] ? (~st[k-1].p2[q] + P2W'(1)) : st[k-1].p2[q];
          m = a * b;
          nxt[k].prod[q] = PX'(m);
          nxt[k].sg[q]   = st[k-1].rho[W-1] ^ st[k-1].p2[q][P2W-1];
        end
      end
    end else if (k == S_T) begin : g_t
      // weight numerator as a shift, add half of 72 for rounding
      always_comb begin
        logic [LW-1:0] r;
        nxt[k] = st[k-1];
        for (int q = 0; q < NDIR; q++) begin
          r = rq(st[k-1].prod[q]);
          nxt[k].dn[q] = (EQ_W'(r) << WK_SHIFT[q]) + EQ_W'(EQ_HALF);
        end
      end
    end else if (k == S_Q0) begin : g_q72_pre
      // flag quotients past the output range, drop the factor of 8, form 7x
      always_comb begin
        logic [EQ_W-1:0] x;
        nxt[k] = st[k-1];
        for (int q = 0; q < NDIR; q++) begin
          nxt[k].big[q] = st[k-1].dn[q] >= (EQ_W'(EQ_DIV) << (W - 1));
          x = st[k-1].dn[q] >> EQ_PRE;
          nxt[k].dn[q] = x;
          nxt[k].dq[q] = (x << 3) - x;
        end
      end
    end else if (k == S_Q0 + 1) begin : g_q72_est
      // x/9 = 7x * (1/64 + 1/64^2 + ...); each truncated term keeps it low
      always_comb begin
        logic [EQ_W-1:0] acc;
        nxt[k] = st[k-1];
        for (int q = 0; q < NDIR; q++) begin
          acc = '0;
          for (int i = 1; i <= EQ_K; i++) begin
            acc = acc + (st[k-1].dq[q] >> (6 * i));
          end
          nxt[k].dq[q] = acc;
        end
      end
    end else if (k < S_DIFF) begin : g_q72_fix
      // estimate is short by at most EQ_K; count the nines left in the remainder, clamp flagged quotients
      always_comb begin
        logic [EQ_W-1:0]  qv;
        logic [EQ_RW-1:0] r;
        nxt[k] = st[k-1];
        for (int q = 0; q < NDIR; q++) begin
          qv = st[k-1].dq[q];
          r  = EQ_RW'(st[k-1].dn[q] - ((qv << 3) + qv));
          for (int j = 1; j <= EQ_K; j++) begin
            if (r >= EQ_RW'(EQ_NINE * j)) begin
              qv = qv + EQ_W'(1);
            end
          end
          nxt[k].dn[q] = st[k-1].big[q] ? (EQ_W'(1) << (W - 1)) : qv;
        end
      end
    end else if (k == S_DIFF) begin : g_diff
      always_comb begin
        logic signed [SW-1:0] t;
        logic [W-1:0]         fe;
        nxt[k] = st[k-1];
        for (int q = 0; q < NDIR; q++) begin
          t = SW'(st[k-1].dn[q]);
          if (st[k-1].sg[q]) begin
            t = -t;
          end
          fe = sat(t);
          nxt[k].diff[q] = (W+1)'(sx(fe) - sx(st[k-1].f[q]));
        end
      end
    end else if (k == S_RP) begin : g_rp
      always_comb begin
        logic [W:0]       ad;
        logic [W+F+1:0]   m;
        nxt[k] = st[k-1];
        for (int q = 0; q < NDIR; q++) begin
          ad = st[k-1].diff[q][W] ? (~st[k-1].diff[q] + (W+1)'(1)) : st[k-1].diff[q];
          m  = ad * relax_rate;
          nxt[k].prod[q] = PX'(m);
          nxt[k].sg[q]   = st[k-1].diff[q][W];
        end
      end
    end else if (k == S_REL) begin : g_rel
      always_comb begin
        logic [RW-1:0] r;
        nxt[k] = st[k-1];
        for (int q = 0; q < NDIR; q++) begin
          r = RW'(rq(st[k-1].prod[q]));
          nxt[k].rel[q] = st[k-1].sg[q] ? (~r + RW'(1)) : r;
        end
      end
    end else begin : g_out
      always_comb begin
        nxt[k] = st[k-1];
        for (int q = 0; q < NDIR; q++) begin
          nxt[k].o[q] = sat(sx(st[k-1].f[q]) + SW'($signed(st[k-1].rel[q])));
        end
      end
    end
  end

  // payload registers; hold a stage while its successor is full and stalled
  always_ff @(posedge clk) begin
    for (int k = 0; k < NS; k++) begin
      if (en[k]) begin
        st[k] <= nxt[k];
      end
    end
  end

  assign out_0      = st[NS-1].o[0];
  assign out_1      = st[NS-1].o[1];
  assign out_2      = st[NS-1].o[2];
  assign out_3      = st[NS-1].o[3];
  assign out_4      = st[NS-1].o[4];
  assign out_5      = st[NS-1].o[5];
  assign out_6      = st[NS-1].o[6];
  assign out_7      = st[NS-1].o[7];
  assign out_8      = st[NS-1].o[8];
  assign density    = st[NS-1].rho;
  assign velocity_x = st[NS-1].ux;
  assign velocity_y = st[NS-1].uy;

endmodule
`default_nettype wire

[hw/rtl/d2q_bgk_chk.sv]
`default_nettype none
`include "assert_macros.svh"
module d2q_bgk_chk #(
  parameter int DATA_WIDTH = 32
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         dist_ready,
  input logic                         result_valid,
  input logic                         result_ready,
  input logic signed [DATA_WIDTH-1:0] density,
  input logic signed [DATA_WIDTH-1:0] velocity_x,
  input logic signed [DATA_WIDTH-1:0] velocity_y
);

  `CHK_NEXT(a_rst_empty, clk, 1'b0, rst, !result_valid)
  `CHK_NEXT(a_out_hold, clk, rst, result_valid && !result_ready, result_valid)
  `CHK_IMPLY(a_empty_ready, clk, rst, !result_valid, dist_ready)
  `CHK_IMPLY(a_still_fluid, clk, rst, result_valid && (density <= 0), (velocity_x == 0) && (velocity_y == 0))

endmodule

bind d2q9_bgk_collision d2q_bgk_chk #(.DATA_WIDTH(DATA_WIDTH)) u_chk (.*);
`default_nettype wire
